FILE: hw/rtl/shex_pkg.sv
// ----------------------------------------------------------------------------
// shex_pkg
// opcodes, status codes, sequencer states and divider control of the stack-machine execute unit
// ----------------------------------------------------------------------------
package shex_pkg;

   typedef enum logic [4:0] {
      OP_PUSH    = 5'd0,
      OP_DUP     = 5'd1,
      OP_COPY    = 5'd2,
      OP_SWAP    = 5'd3,
      OP_POP     = 5'd4,
      OP_SLIDE   = 5'd5,
      OP_ADD     = 5'd6,
      OP_SUB     = 5'd7,
      OP_MUL     = 5'd8,
      OP_DIV     = 5'd9,
      OP_MOD     = 5'd10,
      OP_STORE   = 5'd11,
      OP_RESTORE = 5'd12,
      OP_PUTC    = 5'd13,
      OP_PUTI    = 5'd14,
      OP_READC   = 5'd15,
      OP_READI   = 5'd16
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_FEW     = 3'd2,
      ST_RANGE   = 3'd3,
      ST_NOMATCH = 3'd4,
      ST_DIVZERO = 3'd5,
      ST_BADKEY  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_HEAP,
      S_OUT,
      S_CLEAR
   } state_type;

   typedef struct packed {
      logic start;
      logic want_mod;
   } div_ctl_type;

endpackage

FILE: hw/rtl/shex_divider.sv
// ----------------------------------------------------------------------------
// shex_divider
// signed 32-bit divide and modulo, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module shex_divider
   import shex_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] result
);

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in, mod_ff, mod_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      mod_in  = mod_ff;
      shifted = {rem_ff[31:0], quo_ff[31]};
      trial   = shifted - {1'b0, den_ff};
      done    = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
         den_in  = divisor[31] ? (~divisor + 32'd1) : divisor;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
         mod_in  = ctl.want_mod;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[30:0], 1'b0};
            end
         end
      end
   end

   assign result = mod_ff ? (rneg_ff ? (~rem_ff[31:0] + 32'd1) : rem_ff[31:0])
                          : (qneg_ff ? (~quo_ff + 32'd1) : quo_ff);

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      mod_ff  <= mod_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

endmodule

FILE: hw/rtl/stack_heap_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_heap_execute_unit
// executes one stack-machine instruction per transaction against a stack
// memory and a direct-mapped heap memory
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit first)                      tuser
// req      in   op[4:0], operand[36:5], read_value[68:37]   -
// rsp      out  status[2:0], print_value[34:3]             print_valid, print_is_char
//
// an instruction passes three stack read phases through the registered stack
// memory, then execute; swap and restore add the heap state, and mul, div and
// mod the divide state, where div and mod wait for the divider. the result
// handshake and the return to idle follow before the next transaction is taken.
// after reset the heap is swept entry by entry to clear its valid bits,
// with req_tready low; a pending result holds the unit until rsp_tready takes it.
// ----------------------------------------------------------------------------
module stack_heap_execute_unit
   import shex_pkg::*;
#(
   parameter int STACK_DEPTH = 1024,
   parameter int HEAP_DEPTH  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // op, operand, read_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status, print_value
   output logic [1:0]  rsp_tuser    // print_valid, print_is_char
);

   localparam int SW = $clog2(STACK_DEPTH);
   localparam int HW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [31:0] stack_mem [STACK_DEPTH];
   // heap entry: valid bit on top of the data word
   logic [32:0] heap_mem  [HEAP_DEPTH];

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [4:0]  op_ff;
   logic [31:0] opnd_ff, rd_ff;
   logic [31:0] a_ff, b_ff;
   logic [2:0]  st_ff, st_in;
   logic        pv_ff, pv_in, pch_ff, pch_in;
   logic [31:0] pval_ff, pval_in;

   // stack port
   logic          s_re, s_we;
   logic [SW-1:0] s_raddr, s_waddr;
   logic [31:0]   s_wdata, s_rdata_ff;
   // heap port
   logic          h_re, h_we;
   logic [HW-1:0] h_raddr, h_waddr;
   logic [32:0]   h_wdata, h_rdata_ff;
   logic [HW-1:0] clr_ff, clr_in;

   logic [1:0]  phase_ff, phase_in;
   div_ctl_type dctl;
   logic        ddone;
   logic [31:0] dres;
   logic [31:0] mul_ff;

   logic        accept;
   logic [CW:0] n_ext;
   logic        idx_ok;
   logic        key_ok;
   logic [31:0] key;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, pval_ff, st_ff};
   assign rsp_tuser  = {pch_ff, pv_ff};

   assign n_ext  = {1'b0, count_ff};
   assign idx_ok = !opnd_ff[31] && ({1'b0, opnd_ff} < {{(33-CW-1){1'b0}}, n_ext});
   assign key    = (op_ff == OP_STORE) ? a_ff : b_ff;
   assign key_ok = !key[31] && (key < 32'(HEAP_DEPTH));

   shex_divider u_div (
      .clock(clock), .reset(reset), .ctl(dctl),
      .dividend(a_ff), .divisor(b_ff), .done(ddone), .result(dres)
   );

   always_ff @(posedge clock) begin
      if (s_we) stack_mem[s_waddr] <= s_wdata;
      if (s_re) s_rdata_ff <= stack_mem[s_raddr];
      if (h_we) heap_mem[h_waddr] <= h_wdata;
      if (h_re) h_rdata_ff <= heap_mem[h_raddr];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      st_in    = st_ff;
      pv_in    = pv_ff;
      pch_in   = pch_ff;
      pval_in  = pval_ff;
      phase_in = phase_ff;
      clr_in   = clr_ff;
      s_re = 1'b0; s_we = 1'b0; s_raddr = '0; s_waddr = '0; s_wdata = '0;
      h_re = 1'b0; h_we = 1'b0; h_raddr = key[HW-1:0]; h_waddr = key[HW-1:0];
      h_wdata = '0;
      dctl = '0;
      unique case (state_ff)
         S_CLEAR: begin
            h_we = 1'b1; h_waddr = clr_ff; h_wdata = '0;
            clr_in = clr_ff + HW'(1);
            if (clr_ff == HW'(HEAP_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
               phase_in = 2'd0;
               st_in = ST_OK; pv_in = 1'b0; pch_in = 1'b0; pval_in = '0;
            end
         end
         S_READ: begin
            // phase 0: read top, 1: read second or copy source, 2: capture
            phase_in = phase_ff + 2'd1;
            s_re = 1'b1;
            if (phase_ff == 2'd0) begin
               s_raddr = SW'(count_ff - CW'(1));
            end else begin
               if (op_ff == OP_COPY)
                  s_raddr = SW'(count_ff - CW'(1) - CW'(opnd_ff[CW-1:0]));
               else
                  s_raddr = SW'(count_ff - CW'(2));
               if (phase_ff == 2'd2) begin
                  s_re = 1'b0;
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            unique case (op_ff)
               OP_PUSH: begin
                  if (count_ff == CW'(STACK_DEPTH)) st_in = ST_FULL;
                  else begin
                     s_we = 1'b1; s_waddr = SW'(count_ff); s_wdata = opnd_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_DUP, OP_COPY: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else if (count_ff == CW'(STACK_DEPTH)) st_in = ST_FULL;
                  else if (op_ff == OP_COPY && !idx_ok) st_in = ST_RANGE;
                  else begin
                     s_we = 1'b1; s_waddr = SW'(count_ff);
                     s_wdata = (op_ff == OP_DUP) ? b_ff : a_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_SWAP: begin
                  if (count_ff < CW'(2)) st_in = ST_FEW;
                  else begin
                     // two writes: second goes out on the extra heap phase
                     s_we = 1'b1; s_waddr = SW'(count_ff - CW'(1)); s_wdata = a_ff;
                     state_in = S_HEAP; phase_in = 2'd3;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else count_in = count_ff - CW'(1);
               end
               OP_SLIDE: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else if (!idx_ok) st_in = ST_RANGE;
                  else begin
                     s_we = 1'b1;
                     s_waddr = SW'(count_ff - CW'(1) - CW'(opnd_ff[CW-1:0]));
                     s_wdata = b_ff;
                     count_in = count_ff - CW'(opnd_ff[CW-1:0]);
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                  if (count_ff < CW'(2)) st_in = ST_FEW;
                  else if ((op_ff == OP_DIV || op_ff == OP_MOD) && b_ff == '0)
                     st_in = ST_DIVZERO;
                  else if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                     s_we = 1'b1; s_waddr = SW'(count_ff - CW'(2));
                     s_wdata = (op_ff == OP_ADD) ? a_ff + b_ff : a_ff - b_ff;
                     count_in = count_ff - CW'(1);
                  end else if (op_ff == OP_MUL) begin
                     state_in = S_DIV; phase_in = 2'd1;
                  end else begin
                     dctl.start = 1'b1; dctl.want_mod = (op_ff == OP_MOD);
                     state_in = S_DIV; phase_in = 2'd0;
                  end
               end
               OP_STORE: begin
                  if (count_ff < CW'(2)) st_in = ST_FEW;
                  else if (!key_ok) st_in = ST_BADKEY;
                  else begin
                     h_we = 1'b1; h_wdata = {1'b1, b_ff};
                     count_in = count_ff - CW'(2);
                  end
               end
               OP_RESTORE: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else if (!key_ok) st_in = ST_BADKEY;
                  else begin
                     h_re = 1'b1;
                     state_in = S_HEAP; phase_in = 2'd0;
                  end
               end
               OP_PUTC, OP_PUTI: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else begin
                     pv_in = 1'b1; pval_in = b_ff; pch_in = (op_ff == OP_PUTC);
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_READC, OP_READI: begin
                  if (count_ff == '0) st_in = ST_FEW;
                  else if (!key_ok) st_in = ST_BADKEY;
                  else begin
                     h_we = 1'b1;
                     h_wdata = {1'b1,
                                (op_ff == OP_READC) ? {24'd0, rd_ff[7:0]} : rd_ff};
                     count_in = count_ff - CW'(1);
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (phase_ff == 2'd1 || ddone) begin
               s_we = 1'b1; s_waddr = SW'(count_ff - CW'(2));
               s_wdata = (phase_ff == 2'd1) ? mul_ff : dres;
               count_in = count_ff - CW'(1);
               state_in = S_OUT;
            end
         end
         S_HEAP: begin
            state_in = S_OUT;
            if (phase_ff == 2'd3) begin
               s_we = 1'b1; s_waddr = SW'(count_ff - CW'(2)); s_wdata = b_ff;
            end else if (!h_rdata_ff[32]) begin
               st_in = ST_NOMATCH;
            end else begin
               s_we = 1'b1; s_waddr = SW'(count_ff - CW'(1));
               s_wdata = h_rdata_ff[31:0];
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tdata[4:0];
         opnd_ff <= req_tdata[36:5];
         rd_ff   <= req_tdata[68:37];
      end
      // top arrives at phase 1, second/copy source at phase 2
      if (state_ff == S_READ && phase_ff == 2'd1) b_ff <= s_rdata_ff;
      if (state_ff == S_READ && phase_ff == 2'd2) a_ff <= s_rdata_ff;
      mul_ff   <= a_ff * b_ff;
      st_ff    <= st_in;
      pv_ff    <= pv_in;
      pch_ff   <= pch_in;
      pval_ff  <= pval_in;
      phase_ff <= phase_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
      end
   end

   // stack count never exceeds the stack depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_tready) |=> state_ff == S_OUT && $stable(st_ff))
      else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      s_we |-> state_ff != S_IDLE && state_ff != S_OUT)
      else $error("stack write outside execute");

   assert property (@(posedge clock) disable iff (reset)
      pv_ff && state_ff == S_OUT |-> st_ff == ST_OK)
      else $error("print with error status");

endmodule
